### rtl/core/ttphl_pkg.sv
package ttphl_pkg;

    typedef enum logic [4:0] {
        PH_IDLE, PH_RX_COMMIT, PH_RX_BLO, PH_RX_BHI, PH_RX_PAR, PH_RX_STOP,
        PH_TX_REQ, PH_TX_START, PH_TX_BLO, PH_TX_BHI, PH_TX_PAR, PH_TX_STOP,
        PH_FL_LO, PH_FL_HI, PH_FL_RAISE, PH_GF_P0, PH_GF_P3
    } phase_t;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_QUEUE = 2'd1;
    localparam logic [1:0] CMD_SEND  = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam logic [1:0] DRV_LO  = 2'd0;
    localparam logic [1:0] DRV_HI  = 2'd1;
    localparam logic [1:0] DRV_REL = 2'd2;

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_RX_DONE = 3'd1;
    localparam logic [2:0] ST_TX_DONE = 3'd2;
    localparam logic [2:0] ST_ABORT   = 3'd3;
    localparam logic [2:0] ST_BAD_HDR = 3'd4;
    localparam logic [2:0] ST_FRAMING = 3'd5;
    localparam logic [2:0] ST_GFLUSH  = 3'd6;
    localparam logic [2:0] ST_FL_DONE = 3'd7;

    localparam logic [1:0] REG_WAIT_LIMIT   = 2'd0;
    localparam logic [1:0] REG_FLUSH_CYCLES = 2'd1;
    localparam logic [1:0] REG_RX_KEEP      = 2'd2;
    localparam logic [1:0] REG_AUTO_FLUSH   = 2'd3;

    localparam logic [7:0] HDR_FLAG = 8'h08;
    localparam logic [7:0] HDR_LEN  = 8'h07;

    typedef struct packed {
        logic [1:0] cmd;
        logic       clk_level;
        logic       data_level;
        logic [7:0] tx_byte;
    } in_item_t;

    typedef struct packed {
        logic       ack_level;
        logic [1:0] data_drive;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_is_header;
        logic       rx_last;
        logic [2:0] status;
        logic       parity_mismatch;
        logic       wait_timeout;
        logic       busy_res;
    } out_item_t;

    typedef struct packed {
        logic [15:0] wait_limit;
        logic [7:0]  flush_cycles;
        logic [3:0]  rx_keep;
        logic        auto_flush;
    } cfg_t;

    function automatic logic want_high(input phase_t ph);
        case (ph)
            PH_RX_COMMIT, PH_RX_BHI, PH_RX_STOP, PH_TX_START, PH_TX_BHI,
            PH_TX_STOP, PH_FL_HI, PH_GF_P3: want_high = 1'b1;
            default: want_high = 1'b0;
        endcase
    endfunction

endpackage

### rtl/core/ttphl_if.sv
interface ttphl_in_if
    import ttphl_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ttphl_out_if
    import ttphl_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/ttphl_cfg.sv
module ttphl_cfg
    import ttphl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_limit   <= 16'd10000;
            cfg_reg.flush_cycles <= 8'd36;
            cfg_reg.rx_keep      <= 4'd8;
            cfg_reg.auto_flush   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAIT_LIMIT:   cfg_reg.wait_limit   <= cfg_data;
                REG_FLUSH_CYCLES: cfg_reg.flush_cycles <= cfg_data[7:0];
                REG_RX_KEEP:      cfg_reg.rx_keep      <= cfg_data[3:0];
                REG_AUTO_FLUSH:   cfg_reg.auto_flush   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/ttphl_core.sv
module ttphl_core
    import ttphl_pkg::*;
#(
    parameter int TX_DEPTH = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t res
);

    localparam int QW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    phase_t      phase_reg, phase_next;
    logic [2:0]  bit_reg, bit_next;
    logic [3:0]  byte_reg, byte_next;
    logic [2:0]  plen_reg, plen_next;
    logic [7:0]  shift_reg, shift_next;
    logic        par_reg, par_next;
    logic [15:0] wait_reg, wait_next;
    logic [7:0]  fl_reg, fl_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        ack_reg, ack_next;
    logic [1:0]  data_reg, data_next;
    logic [7:0]  queue_mem [TX_DEPTH];
    logic        qwe;

    logic [15:0] wait_inc;
    logic [4:0]  byte5;
    logic        go;
    logic        sending;
    logic        b;

    always_comb
    begin
        phase_next = phase_reg; bit_next = bit_reg; byte_next = byte_reg;
        plen_next = plen_reg; shift_next = shift_reg; par_next = par_reg;
        wait_next = wait_reg; fl_next = fl_reg; cnt_next = cnt_reg;
        ack_next = ack_reg; data_next = data_reg;
        qwe = 1'b0;
        res = '0;
        go = 1'b0;
        b = 1'b0;
        byte5 = {1'b0, byte_reg};
        wait_inc = wait_reg + 16'd1;
        sending = (phase_reg >= PH_TX_REQ) && (phase_reg <= PH_TX_STOP);
        if (step)
        begin
            unique case (item.cmd)
                CMD_QUEUE:
                begin
                    if (!sending && cnt_reg < 5'(TX_DEPTH))
                    begin
                        qwe = 1'b1;
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
                CMD_SEND:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        data_next = DRV_LO; byte_next = '0; bit_next = '0;
                        par_next = 1'b0; wait_next = '0; phase_next = PH_TX_REQ;
                    end
                end
                CMD_FLUSH:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        data_next = DRV_LO; fl_next = '0; wait_next = '0;
                        phase_next = (cfg.flush_cycles != 0) ? PH_FL_LO : PH_FL_RAISE;
                    end
                end
                default:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (!item.clk_level)
                        begin
                            ack_next = 1'b0; wait_next = '0; phase_next = PH_RX_COMMIT;
                        end
                    end
                    else
                    begin
                        if (item.clk_level == want_high(phase_reg))
                            go = 1'b1;
                        else
                        begin
                            wait_next = wait_inc;
                            if (wait_inc >= cfg.wait_limit)
                            begin
                                go = 1'b1;
                                res.wait_timeout = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end

        if (go)
        begin
            wait_next = '0;
            unique case (phase_reg)
                PH_RX_COMMIT:
                begin
                    data_next = DRV_REL; ack_next = 1'b1;
                    if (item.data_level)
                        res.status = ST_ABORT;
                    else
                    begin
                        byte_next = '0; plen_next = '0; bit_next = '0;
                        shift_next = '0; par_next = 1'b0; phase_next = PH_RX_BLO;
                    end
                end
                PH_RX_BLO:
                begin
                    shift_next = shift_reg | (8'(item.data_level) << bit_reg);
                    par_next = par_reg ^ item.data_level;
                    bit_next = bit_reg + 3'd1;
                    ack_next = 1'b0; phase_next = PH_RX_BHI;
                end
                PH_RX_BHI:
                begin
                    shift_next = shift_reg | (8'(item.data_level) << bit_reg);
                    par_next = par_reg ^ item.data_level;
                    bit_next = bit_reg + 3'd1;
                    ack_next = 1'b1;
                    if (bit_next != 0)
                        phase_next = PH_RX_BLO;
                    else if (byte_reg == 0 && (shift_next & HDR_FLAG) == 0)
                        res.status = ST_BAD_HDR;
                    else
                    begin
                        if (byte_reg == 0) plen_next = shift_next[2:0];
                        if (byte_reg < cfg.rx_keep)
                        begin
                            res.rx_valid = 1'b1;
                            res.rx_byte = shift_next;
                            res.rx_is_header = (byte_reg == 0);
                            res.rx_last = (byte_reg == {1'b0, plen_next});
                        end
                        shift_next = '0;
                        if (byte_reg >= {1'b0, plen_next})
                            phase_next = PH_RX_PAR;
                        else
                        begin
                            byte_next = byte_reg + 4'd1;
                            phase_next = PH_RX_BLO;
                        end
                    end
                end
                PH_RX_PAR:
                begin
                    par_next = item.data_level != par_reg;
                    ack_next = 1'b0; phase_next = PH_RX_STOP;
                end
                PH_RX_STOP:
                begin
                    ack_next = 1'b1;
                    res.parity_mismatch = par_reg;
                    if (!item.data_level)
                        res.status = ST_FRAMING;
                    else
                    begin
                        res.status = ST_RX_DONE; phase_next = PH_IDLE;
                    end
                end
                PH_TX_REQ:
                begin
                    ack_next = 1'b0; phase_next = PH_TX_START;
                end
                PH_TX_START, PH_TX_BHI:
                begin
                    if (phase_reg == PH_TX_BHI && bit_reg != 0)
                    begin
                        b = shift_reg[bit_reg];
                        data_next = {1'b0, b}; par_next = par_reg ^ b;
                        bit_next = bit_reg + 3'd1;
                        ack_next = 1'b1; phase_next = PH_TX_BLO;
                    end
                    else
                    begin
                        if (phase_reg == PH_TX_BHI) byte5 = {1'b0, byte_reg} + 5'd1;
                        byte_next = byte5[3:0];
                        if (byte5 < cnt_reg)
                        begin
                            shift_next = (byte5 < 5'(TX_DEPTH)) ? queue_mem[byte5[QW-1:0]]
                                                              : 8'd0;
                            b = shift_next[0];
                            data_next = {1'b0, b}; par_next = par_reg ^ b;
                            bit_next = 3'd1;
                            ack_next = 1'b1; phase_next = PH_TX_BLO;
                        end
                        else
                        begin
                            data_next = {1'b0, par_reg}; ack_next = 1'b1;
                            phase_next = PH_TX_PAR;
                        end
                    end
                end
                PH_TX_BLO:
                begin
                    b = shift_reg[bit_reg];
                    data_next = {1'b0, b}; par_next = par_reg ^ b;
                    bit_next = bit_reg + 3'd1;
                    ack_next = 1'b0; phase_next = PH_TX_BHI;
                end
                PH_TX_PAR:
                begin
                    data_next = DRV_HI; ack_next = 1'b0; phase_next = PH_TX_STOP;
                end
                PH_TX_STOP:
                begin
                    data_next = DRV_REL; cnt_next = '0; ack_next = 1'b1;
                    if (!item.data_level)
                    begin
                        res.status = ST_GFLUSH;
                        phase_next = item.clk_level ? PH_GF_P0 : PH_GF_P3;
                    end
                    else
                    begin
                        res.status = ST_TX_DONE; phase_next = PH_IDLE;
                    end
                end
                PH_FL_LO:
                begin
                    ack_next = 1'b0; phase_next = PH_FL_HI;
                end
                PH_FL_HI:
                begin
                    ack_next = 1'b1; fl_next = fl_reg + 8'd1;
                    phase_next = (fl_next >= cfg.flush_cycles) ? PH_FL_RAISE : PH_FL_LO;
                end
                PH_FL_RAISE:
                begin
                    ack_next = 1'b1;
                    if (!item.clk_level)
                    begin
                        data_next = DRV_HI; phase_next = PH_GF_P3;
                    end
                    else
                    begin
                        data_next = DRV_REL;
                        if (item.data_level)
                        begin
                            res.status = ST_FL_DONE; phase_next = PH_IDLE;
                        end
                        else
                            phase_next = PH_GF_P0;
                    end
                end
                PH_GF_P0:
                begin
                    ack_next = 1'b0; phase_next = PH_GF_P3;
                end
                PH_GF_P3:
                begin
                    data_next = DRV_REL; ack_next = 1'b1;
                    if (item.data_level)
                    begin
                        res.status = ST_FL_DONE; phase_next = PH_IDLE;
                    end
                    else
                        phase_next = PH_GF_P0;
                end
                default: phase_next = PH_IDLE;
            endcase
            if (res.status == ST_ABORT || res.status == ST_BAD_HDR
                || res.status == ST_FRAMING)
            begin
                if (cfg.auto_flush)
                begin
                    data_next = DRV_LO; fl_next = '0; wait_next = '0;
                    phase_next = (cfg.flush_cycles != 0) ? PH_FL_LO : PH_FL_RAISE;
                end
                else
                begin
                    phase_next = PH_IDLE; data_next = DRV_REL;
                end
            end
        end
        res.ack_level = ack_next;
        res.data_drive = data_next;
        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; bit_reg <= '0; byte_reg <= '0; plen_reg <= '0;
            shift_reg <= '0; par_reg <= 1'b0; wait_reg <= '0; fl_reg <= '0;
            cnt_reg <= '0; ack_reg <= 1'b1; data_reg <= DRV_REL;
        end
        else
        begin
            phase_reg <= phase_next; bit_reg <= bit_next; byte_reg <= byte_next;
            plen_reg <= plen_next; shift_reg <= shift_next; par_reg <= par_next;
            wait_reg <= wait_next; fl_reg <= fl_next; cnt_reg <= cnt_next;
            ack_reg <= ack_next; data_reg <= data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (qwe)
            queue_mem[cnt_reg[QW-1:0]] <= item.tx_byte;
    end

endmodule

### rtl/core/three_wire_touchpad_host_link.sv
// Channel   Direction  Payload
// in_ch     sink       cmd, clk_level, data_level, tx_byte
// out_ch    source     ack_level, data_drive, rx_byte, rx_valid, rx_is_header,
//                      rx_last, status, parity_mismatch, wait_timeout, busy_res
// One transaction in, one out; a new transaction each cycle while the output is not stalled.
// The result appears from the result register in the cycle after acceptance.
// Input is taken while the result register is empty or being drained.
// Reset returns the link to idle with ACK high and DATA released.
module three_wire_touchpad_host_link
    import ttphl_pkg::*;
#(
    parameter int TX_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    ttphl_in_if.sink    in_ch,
    ttphl_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t      cfg;
    out_item_t res;
    out_item_t res_reg;
    logic      valid_reg;
    logic      step;

    assign in_ch.ready = !valid_reg || out_ch.ready;
    assign step = in_ch.valid && in_ch.ready;

    ttphl_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    ttphl_core #(.TX_DEPTH(TX_DEPTH)) u_core (
        .clk(clk), .rst_n(rst_n), .step(step), .item(in_ch.payload),
        .cfg(cfg), .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ch.ready)
            valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.payload = res_reg;

endmodule

### rtl/core/ttphl_checker.sv
module ttphl_checker
    import ttphl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_item_t out_payload
);

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input stalled with empty output");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid) else $error("accepted transaction lost");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("stalled result changed");
    a_rx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_payload.rx_valid |-> out_payload.rx_byte == 8'd0)
        else $error("rx_byte without rx_valid");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.status != ST_NONE && out_payload.status != ST_GFLUSH
        && !out_payload.busy_res |-> out_payload.data_drive == DRV_REL)
        else $error("idle end without released data");

endmodule

bind three_wire_touchpad_host_link ttphl_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
